### src/and_instruction_with_addressing_core_macros.svh
// ----------------------------------------------------------------------------
// AND instruction core assertion macros
// Concurrent assertion forms for the AND instruction core sequencer.
// ----------------------------------------------------------------------------
`ifndef AND_INSTRUCTION_WITH_ADDRESSING_CORE_MACROS_SVH
`define AND_INSTRUCTION_WITH_ADDRESSING_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIWA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AIWA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/aiwa_pkg.sv
// ----------------------------------------------------------------------------
// AND instruction core package
// Word types, addressing mode codes and sequencer states shared by the core.
// ----------------------------------------------------------------------------
package aiwa_pkg;

    localparam int unsigned ADDR_BITS_DEF = 16;

    // Addressing mode codes carried in the mode field of an input word.
    localparam logic [3:0] MODE_WRITE = 4'd0;
    localparam logic [3:0] MODE_IMM   = 4'd1;
    localparam logic [3:0] MODE_ZP    = 4'd2;
    localparam logic [3:0] MODE_ZPX   = 4'd3;
    localparam logic [3:0] MODE_ABS   = 4'd4;
    localparam logic [3:0] MODE_ABSX  = 4'd5;
    localparam logic [3:0] MODE_ABSY  = 4'd6;
    localparam logic [3:0] MODE_INDX  = 4'd7;
    localparam logic [3:0] MODE_INDY  = 4'd8;

    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  reg_a;
        logic [7:0]  reg_x;
        logic [7:0]  reg_y;
        logic [1:0]  instr_size;
        logic [2:0]  base_cycles;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic        flag_n;
        logic        flag_z;
        logic [15:0] next_pc;
        logic [3:0]  cycle_count;
        logic [15:0] eff_address;
        logic        address_valid;
    } out_word_t;

    // One access of the byte memory.
    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP1,
        ST_OP2,
        ST_PTRL,
        ST_PTRH,
        ST_DATA,
        ST_HOLD
    } seq_state_t;

endpackage

### src/and_instruction_with_addressing_core.sv
// ----------------------------------------------------------------------------
// AND instruction core
// Executes the AND instruction in eight addressing modes over a private byte
// memory that write words fill.
// ----------------------------------------------------------------------------
//  Channel  Ports                      Carries
//  input    s_valid s_ready s_data     memory write or instruction word
//  result   m_valid m_ready m_data     accumulator, flags, next PC, cycles, address
//
// One word is worked at a time, since every read goes through the single memory port.
// A write word is stored as it is accepted. An instruction word reads its operand, then
// the high address byte (absolute) or pointer bytes (indirect), then data (not immediate).
// A finished result moves into the output register, so the next word is taken while
// it waits; a result blocked behind a full output register is parked in the sequencer.
// Reset clears only control state; the memory holds no defined value until written.
// ----------------------------------------------------------------------------
module and_instruction_with_addressing_core #(
    parameter int unsigned ADDR_BITS = aiwa_pkg::ADDR_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aiwa_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aiwa_pkg::out_word_t m_data
);
    import aiwa_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;

    logic       res_valid;
    logic       res_ready;
    out_word_t  res_data;

    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;

    // The byte memory holds the bytes that write words store and instruction words read.
    aiwa_mem #(
        .ADDR_BITS(ADDR_BITS)
    ) u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The sequencer issues the memory writes and the operand, pointer and data reads for each word.
    aiwa_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/aiwa_mem.sv
// ----------------------------------------------------------------------------
// AND instruction core byte memory
// Single-port synchronous byte memory with a registered read port.
// ----------------------------------------------------------------------------
module aiwa_mem #(
    parameter int unsigned ADDR_BITS = aiwa_pkg::ADDR_BITS_DEF
) (
    input  logic              aclk,
    input  aiwa_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import aiwa_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rdata_reg;

    // Addresses above the memory size alias onto the low bits.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_array[req.addr[ADDR_BITS-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem_array[req.addr[ADDR_BITS-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/aiwa_seq.sv
// ----------------------------------------------------------------------------
// AND instruction core sequencer
// Stores write words and walks the operand, pointer and data reads of one instruction word.
// ----------------------------------------------------------------------------
`include "and_instruction_with_addressing_core_macros.svh"

module aiwa_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aiwa_pkg::in_word_t  s_data,
    output aiwa_pkg::mem_req_t  mem_req,
    input  logic [7:0]          mem_rdata,
    output logic                res_valid,
    input  logic                res_ready,
    output aiwa_pkg::out_word_t res_data
);
    import aiwa_pkg::*;

    seq_state_t state_reg, state_next;
    in_word_t   item_reg, item_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  zp_reg, zp_next;
    logic [15:0] ea_reg, ea_next;
    logic        cross_reg, cross_next;
    logic [7:0]  opnd_reg, opnd_next;

    logic        s_accept;
    logic        instr_mode;
    logic        finish;
    logic [7:0]  operand;
    logic [15:0] base;
    logic [7:0]  idx;
    logic [7:0]  acc;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign instr_mode = (s_data.mode >= MODE_IMM) && (s_data.mode <= MODE_INDY);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && instr_mode) begin
                    state_next = ST_OP1;
                end
            end
            ST_OP1: begin
                case (item_reg.mode) inside
                    MODE_IMM:                       state_next = res_ready ? ST_IDLE : ST_HOLD;
                    MODE_ZP, MODE_ZPX:              state_next = ST_DATA;
                    MODE_ABS, MODE_ABSX, MODE_ABSY: state_next = ST_OP2;
                    default:                        state_next = ST_PTRL;
                endcase
            end
            ST_OP2:  state_next = ST_DATA;
            ST_PTRL: state_next = ST_PTRH;
            ST_PTRH: state_next = ST_DATA;
            ST_DATA: state_next = res_ready ? ST_IDLE : ST_HOLD;
            ST_HOLD: state_next = res_ready ? ST_IDLE : ST_HOLD;
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory requests, address arithmetic and datapath captures.
    always_comb begin
        mem_req    = '0;
        item_next  = item_reg;
        lo_next    = lo_reg;
        zp_next    = zp_reg;
        ea_next    = ea_reg;
        cross_next = cross_reg;
        opnd_next  = opnd_reg;
        finish     = 1'b0;
        operand    = opnd_reg;
        base       = {mem_rdata, lo_reg};
        idx        = 8'h00;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    ea_next    = '0;
                    cross_next = 1'b0;
                    if (s_data.mode == MODE_WRITE) begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = s_data.mem_addr;
                        mem_req.wdata = s_data.mem_data;
                    end else if (instr_mode) begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = 16'(s_data.pc + 16'd1);
                    end
                end
            end
            ST_OP1: begin
                case (item_reg.mode) inside
                    MODE_IMM: begin
                        finish  = 1'b1;
                        operand = mem_rdata;
                    end
                    MODE_ZP: begin
                        ea_next      = {8'h00, mem_rdata};
                        mem_req.re   = 1'b1;
                        mem_req.addr = ea_next;
                    end
                    MODE_ZPX: begin
                        ea_next      = {8'h00, 8'(mem_rdata + item_reg.reg_x)};
                        mem_req.re   = 1'b1;
                        mem_req.addr = ea_next;
                    end
                    MODE_ABS, MODE_ABSX, MODE_ABSY: begin
                        lo_next      = mem_rdata;
                        mem_req.re   = 1'b1;
                        mem_req.addr = 16'(item_reg.pc + 16'd2);
                    end
                    MODE_INDX: begin
                        zp_next      = 8'(mem_rdata + item_reg.reg_x);
                        mem_req.re   = 1'b1;
                        mem_req.addr = {8'h00, zp_next};
                    end
                    default: begin
                        zp_next      = mem_rdata;
                        mem_req.re   = 1'b1;
                        mem_req.addr = {8'h00, zp_next};
                    end
                endcase
            end
            ST_OP2: begin
                if (item_reg.mode == MODE_ABSX) begin
                    idx = item_reg.reg_x;
                end else if (item_reg.mode == MODE_ABSY) begin
                    idx = item_reg.reg_y;
                end
                ea_next      = 16'(base + {8'h00, idx});
                cross_next   = (ea_next[15:8] != base[15:8]);
                mem_req.re   = 1'b1;
                mem_req.addr = ea_next;
            end
            ST_PTRL: begin
                lo_next      = mem_rdata;
                mem_req.re   = 1'b1;
                mem_req.addr = {8'h00, 8'(zp_reg + 8'd1)};
            end
            ST_PTRH: begin
                if (item_reg.mode == MODE_INDY) begin
                    idx = item_reg.reg_y;
                end
                ea_next      = 16'(base + {8'h00, idx});
                cross_next   = (ea_next[15:8] != base[15:8]);
                mem_req.re   = 1'b1;
                mem_req.addr = ea_next;
            end
            ST_DATA: begin
                finish  = 1'b1;
                operand = mem_rdata;
            end
            ST_HOLD: begin
                finish = 1'b1;
            end
            default: begin
                finish = 1'b0;
            end
        endcase
        // Park the operand when the output stage is full, so ST_HOLD can rebuild the result from opnd_reg.
        if (finish && !res_ready) begin
            opnd_next = operand;
        end
    end

    assign acc       = item_reg.reg_a & operand;
    assign res_valid = finish;

    always_comb begin
        res_data.acc_out       = acc;
        res_data.flag_n        = acc[7];
        res_data.flag_z        = (acc == 8'h00);
        res_data.next_pc       = 16'(item_reg.pc + {14'b0, item_reg.instr_size});
        res_data.cycle_count   = 4'({1'b0, item_reg.base_cycles} + {3'b000, cross_reg});
        res_data.eff_address   = ea_reg;
        res_data.address_valid = (item_reg.mode != MODE_IMM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        lo_reg    <= lo_next;
        zp_reg    <= zp_next;
        ea_reg    <= ea_next;
        cross_reg <= cross_next;
        opnd_reg  <= opnd_next;
    end

    `AIWA_ASSERT_SAME(a_write_only_idle, aclk, aresetn, mem_req.we, state_reg == ST_IDLE, "memory write outside idle")
    `AIWA_ASSERT_SAME(a_single_port, aclk, aresetn, mem_req.we, !mem_req.re, "memory read and write in one cycle")
    `AIWA_ASSERT_NEXT(a_issue_op1, aclk, aresetn, s_accept && instr_mode, state_reg == ST_OP1, "instruction word did not start its operand read")
    `AIWA_ASSERT_NEXT(a_hold_result, aclk, aresetn, res_valid && !res_ready, res_valid && (state_reg == ST_HOLD), "stalled result was dropped")

endmodule

### test/and_instruction_with_addressing_core_tb.sv
// ----------------------------------------------------------------------------
// AND instruction core testbench
// Drives memory write and AND instruction words into the core under random
// idling and back-pressure. Each result word is checked against a local model
// of the core and its byte memory.
// ----------------------------------------------------------------------------
module and_instruction_with_addressing_core_tb;
    import aiwa_pkg::*;

    localparam int unsigned ADDR_BITS = 16;
    localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;
    localparam logic [15:0] ADDR_MASK = 16'(MEM_DEPTH - 1);

    // No word may go unaccepted on both channels for this long. The longest
    // legitimate quiet stretch is the deliberate receiver hold-off below.
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles to keep watching once nothing is expected, to catch stray results.
    localparam int DRAIN_TAIL     = 20;
    localparam int REPORT_LIMIT   = 10;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Local image of the core's byte memory. The written flags keep the
    // stimulus from ever reading a byte the core has not been given.
    bit [7:0] mem_image [0:MEM_DEPTH-1];
    bit       mem_written [0:MEM_DEPTH-1];

    out_word_t expected_results[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;
    int words_sent;
    int fail_count;
    int stall_cycles;

    and_instruction_with_addressing_core #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Model of the core
    // ------------------------------------------------------------------------

    function automatic logic [7:0] image_byte(input logic [15:0] addr);
        return mem_image[addr & ADDR_MASK];
    endfunction

    // Walks the addressing mode against the memory image. It returns how many
    // bytes the instruction reads and lists them in read order, so the last one
    // is always the data byte. It also gives the effective address and whether
    // indexing moved the address into another page. Unused modes read nothing.
    function automatic int trace_operand(input in_word_t w,
                                         output logic [3:0][15:0] reads,
                                         output logic [15:0] ea,
                                         output logic crossed);
        logic [15:0] op1;
        logic [15:0] op2;
        logic [15:0] base;
        logic [7:0]  zp;
        logic [7:0]  zp_next;
        int          n;
        op1     = w.pc + 16'd1;
        op2     = w.pc + 16'd2;
        reads   = '0;
        ea      = '0;
        crossed = 1'b0;
        n       = 0;
        case (w.mode)
            MODE_IMM: begin
                // The data byte is the operand itself; no address is formed.
                reads[0] = op1;
                n = 1;
            end
            MODE_ZP, MODE_ZPX: begin
                zp = image_byte(op1);
                if (w.mode == MODE_ZPX) zp = zp + w.reg_x;
                ea = {8'h00, zp};
                reads[0] = op1;
                reads[1] = ea;
                n = 2;
            end
            MODE_ABS, MODE_ABSX, MODE_ABSY: begin
                base = {image_byte(op2), image_byte(op1)};
                if (w.mode == MODE_ABSX) ea = base + {8'h00, w.reg_x};
                else if (w.mode == MODE_ABSY) ea = base + {8'h00, w.reg_y};
                else ea = base;
                crossed = (base[15:8] != ea[15:8]);
                reads[0] = op1;
                reads[1] = op2;
                reads[2] = ea;
                n = 3;
            end
            MODE_INDX, MODE_INDY: begin
                zp = image_byte(op1);
                if (w.mode == MODE_INDX) zp = zp + w.reg_x;
                // The pointer high byte stays within the zero page.
                zp_next = zp + 8'd1;
                base = {image_byte({8'h00, zp_next}), image_byte({8'h00, zp})};
                if (w.mode == MODE_INDY) begin
                    ea = base + {8'h00, w.reg_y};
                    crossed = (base[15:8] != ea[15:8]);
                end else begin
                    ea = base;
                end
                reads[0] = op1;
                reads[1] = {8'h00, zp};
                reads[2] = {8'h00, zp_next};
                reads[3] = ea;
                n = 4;
            end
            default: n = 0;
        endcase
        return n;
    endfunction

    // Applies one accepted word to the model and queues the result it causes.
    task automatic predict_and_result(input in_word_t w);
        logic [3:0][15:0] reads;
        logic [15:0]      ea;
        logic             crossed;
        logic [7:0]       acc;
        out_word_t        r;
        int               n;
        if (w.mode == MODE_WRITE) begin
            mem_image[w.mem_addr & ADDR_MASK]   = w.mem_data;
            mem_written[w.mem_addr & ADDR_MASK] = 1'b1;
        end else begin
            n = trace_operand(w, reads, ea, crossed);
            if (n != 0) begin
                acc             = w.reg_a & image_byte(reads[n-1]);
                r.acc_out       = acc;
                r.flag_n        = acc[7];
                r.flag_z        = (acc == 8'h00);
                r.next_pc       = w.pc + {14'd0, w.instr_size};
                r.cycle_count   = {1'b0, w.base_cycles} + {3'd0, crossed};
                r.eff_address   = (w.mode == MODE_IMM) ? 16'h0000 : ea;
                r.address_valid = (w.mode != MODE_IMM);
                expected_results.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_fields();
        in_word_t w;
        w.mode        = 4'($urandom);
        w.pc          = 16'($urandom);
        w.reg_a       = 8'($urandom);
        w.reg_x       = 8'($urandom);
        w.reg_y       = 8'($urandom);
        w.instr_size  = 2'($urandom);
        w.base_cycles = 3'($urandom);
        w.mem_addr    = 16'($urandom);
        w.mem_data    = 8'($urandom);
        return w;
    endfunction

    // Offers one word and returns in the cycle it is accepted. Valid is only
    // dropped when the sender decides to idle before the word, so back-to-back
    // words keep valid high across the boundary.
    task automatic send_word(input in_word_t w);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_and_result(w);
        if (w.mode <= MODE_INDY) words_sent++;
    endtask

    task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
        in_word_t w;
        w          = random_fields();
        w.mode     = MODE_WRITE;
        w.mem_addr = addr;
        w.mem_data = data;
        send_word(w);
    endtask

    // Sends an instruction after making sure every byte it reads has been
    // written. With keep_bytes clear, bytes along the read chain are also
    // rewritten at random so that stale contents get refreshed. Since a write
    // can move a later address of the chain, the chain is walked again until
    // it reads only written bytes.
    task automatic issue_and(input in_word_t w, input bit keep_bytes);
        logic [3:0][15:0] reads;
        logic [15:0]      ea;
        logic             crossed;
        int               n;
        bit               filled;
        n = trace_operand(w, reads, ea, crossed);
        for (int k = 0; k < n; k++) begin
            n = trace_operand(w, reads, ea, crossed);
            if (!mem_written[reads[k] & ADDR_MASK] || (!keep_bytes && $urandom_range(0, 1)))
                send_write(reads[k], pick_byte());
        end
        do begin
            filled = 1'b0;
            n = trace_operand(w, reads, ea, crossed);
            for (int k = 0; k < n; k++) begin
                if (!filled && !mem_written[reads[k] & ADDR_MASK]) begin
                    send_write(reads[k], pick_byte());
                    filled = 1'b1;
                end
            end
        end while (filled);
        send_word(w);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Immediate mode with the operand fetch wrapping from 0xFFFF to 0x0000, a
    // negative result, a zero result, and the smallest and largest size and
    // cycle fields.
    task automatic test_immediate();
        in_word_t w;
        send_write(16'h0000, 8'h80);
        w             = random_fields();
        w.mode        = MODE_IMM;
        w.pc          = 16'hFFFF;
        w.reg_a       = 8'hFF;
        w.instr_size  = 2'd0;
        w.base_cycles = 3'd0;
        issue_and(w, 1'b1);
        w.reg_a       = 8'h7F;
        w.instr_size  = 2'd3;
        w.base_cycles = 3'd7;
        issue_and(w, 1'b1);
    endtask

    // Zero page X where the sum wraps at 256, then plain zero page.
    task automatic test_zero_page();
        in_word_t w;
        send_write(16'h1001, 8'hF0);
        send_write(16'h0010, 8'h5A);
        w       = random_fields();
        w.mode  = MODE_ZPX;
        w.pc    = 16'h1000;
        w.reg_x = 8'h20;
        issue_and(w, 1'b1);
        w.mode  = MODE_ZP;
        issue_and(w, 1'b1);
    endtask

    // Absolute modes with and without a page cross, including a cross that
    // wraps from 0xFFFF to 0x0000.
    task automatic test_indexed_page_cross();
        in_word_t w;
        send_write(16'h2001, 8'hF0);
        send_write(16'h2002, 8'h12);
        w             = random_fields();
        w.mode        = MODE_ABSX;
        w.pc          = 16'h2000;
        w.reg_x       = 8'h20;
        w.base_cycles = 3'd7;
        issue_and(w, 1'b1);
        w.mode        = MODE_ABS;
        issue_and(w, 1'b1);
        w.mode        = MODE_ABSY;
        w.reg_y       = 8'h00;
        issue_and(w, 1'b1);
        send_write(16'h3001, 8'hFF);
        send_write(16'h3002, 8'hFF);
        w.pc          = 16'h3000;
        w.reg_y       = 8'h01;
        issue_and(w, 1'b1);
    endtask

    // Indirect modes whose pointer sits at 0xFF, so its high byte comes from
    // 0x00; (indirect),Y then crosses a page.
    task automatic test_indirect();
        in_word_t w;
        send_write(16'h4001, 8'hFE);
        send_write(16'h00FF, 8'h34);
        w       = random_fields();
        w.mode  = MODE_INDX;
        w.pc    = 16'h4000;
        w.reg_x = 8'h01;
        issue_and(w, 1'b1);
        send_write(16'h5001, 8'hFF);
        w.mode  = MODE_INDY;
        w.pc    = 16'h5000;
        w.reg_y = 8'hD0;
        issue_and(w, 1'b1);
    endtask

    // Mode codes past the last addressing mode must be dropped silently.
    task automatic test_unused_modes();
        in_word_t w;
        w      = random_fields();
        w.mode = 4'd9;
        send_word(w);
        send_word('1);
    endtask

    // Mostly complete instructions with random registers and random memory
    // contents, with stray writes and unused mode codes mixed in.
    task automatic test_random_traffic(input int word_count);
        in_word_t w;
        int       target;
        int       pick;
        target = words_sent + word_count;
        while (words_sent < target) begin
            w    = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                w.mode = 4'($urandom_range(MODE_IMM, MODE_INDY));
                // Keep the operand fetch wrapping past 0xFFFF in the mix.
                if ($urandom_range(0, 15) == 0) w.pc = 16'hFFFE + 16'($urandom_range(0, 1));
                issue_and(w, 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                w.mode = MODE_WRITE;
                send_word(w);
            end else begin
                w.mode = 4'($urandom_range(9, 15));
                send_word(w);
            end
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the output register and the parked result fill and s_ready drops.
    task automatic test_backpressure();
        in_word_t w;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 30; i++) begin
            w      = random_fields();
            w.mode = 4'($urandom_range(MODE_IMM, MODE_INDY));
            issue_and(w, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------------

    // At each edge the accepted result, if any, is compared with the oldest
    // expectation. Then m_ready for the next cycle is chosen: low while a
    // hold-off is running, otherwise low at random per the idle percentage.
    initial begin
        out_word_t exp_word;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("unexpected result word: acc=%h pc=%h ea=%h",
                                 m_data.acc_out, m_data.next_pc, m_data.eff_address);
                    fail_count++;
                end else begin
                    exp_word = expected_results.pop_front();
                    if (m_data.acc_out       !== exp_word.acc_out     ||
                        m_data.flag_n        !== exp_word.flag_n      ||
                        m_data.flag_z        !== exp_word.flag_z      ||
                        m_data.next_pc       !== exp_word.next_pc     ||
                        m_data.cycle_count   !== exp_word.cycle_count ||
                        m_data.eff_address   !== exp_word.eff_address ||
                        m_data.address_valid !== exp_word.address_valid) begin
                        if (fail_count < REPORT_LIMIT)
                            $display({"result mismatch: expected acc=%h n=%b z=%b pc=%h ",
                                      "cyc=%0d ea=%h av=%b, got acc=%h n=%b z=%b pc=%h ",
                                      "cyc=%0d ea=%h av=%b"},
                                     exp_word.acc_out, exp_word.flag_n, exp_word.flag_z,
                                     exp_word.next_pc, exp_word.cycle_count,
                                     exp_word.eff_address, exp_word.address_valid,
                                     m_data.acc_out, m_data.flag_n, m_data.flag_z,
                                     m_data.next_pc, m_data.cycle_count,
                                     m_data.eff_address, m_data.address_valid);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // The watchdog restarts whenever a word moves on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_data         <= '0;
        tx_idle_pct    = 29;
        rx_idle_pct    = 54;
        rx_hold_cycles = 0;
        words_sent     = 0;
        fail_count     = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // First phase: the sender idles now and then, the receiver often.
        test_immediate();
        test_zero_page();
        test_indexed_page_cross();
        test_indirect();
        test_unused_modes();
        test_random_traffic(400);

        // Second phase: the two sides swap their idle rates.
        tx_idle_pct = 54;
        rx_idle_pct = 29;
        test_random_traffic(400);

        // Third phase: nobody idles, apart from the long hold-off at its start.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random_traffic(400);

        // Let the last words drain, then watch a little longer for strays.
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
